>>> src/ssspg_pkg.sv
`timescale 1ns / 1ps

package ssspg_pkg;

  localparam int IDX_W   = 9;
  localparam int VALUE_W = 8;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 24;
  localparam int OFF_W   = 10;
  localparam int SEG_N   = 7;
  localparam int DIGIT_N = 2;

  localparam logic [VALUE_W-1:0] BLANK_VALUE = 8'd255;
  localparam logic [COLOR_W-1:0] ON_COLOR_RST = 24'hFFA500;
  localparam logic [CHAN_W-1:0]  BRIGHT_RST   = 8'd255;
  localparam logic [CHAN_W-1:0]  CHAN_FULL    = 8'd255;
  localparam logic [CHAN_W-1:0]  CHAN_ZERO    = 8'd0;

  typedef enum logic [1:0] {
    CFG_ON_COLOR   = 2'd0,
    CFG_BRIGHTNESS = 2'd1,
    CFG_MODE       = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    MODE_RUN   = 2'd0,
    MODE_STOP  = 2'd1,
    MODE_RESET = 2'd2,
    MODE_ERROR = 2'd3
  } mode_t;

  typedef struct packed {
    logic [VALUE_W-1:0] shown_value;
    logic [IDX_W-1:0]   led_pos;
  } in_data_t;

  typedef struct packed {
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] blue_out;
  } out_data_t;

  // bit 0 = segment a ... bit 6 = segment g
  localparam logic [SEG_N-1:0] SEG_TABLE [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  // segment layout a..g: horizontal runs before, vertical runs before, orientation
  localparam int SEG_NH    [SEG_N] = '{0, 1, 1, 1, 2, 2, 2};
  localparam int SEG_NV    [SEG_N] = '{0, 0, 1, 2, 2, 3, 4};
  localparam int SEG_HORIZ [SEG_N] = '{1, 0, 0, 1, 0, 0, 1};

endpackage

>>> src/ssspg_seg_hit.sv
`timescale 1ns / 1ps

module ssspg_seg_hit
  import ssspg_pkg::*;
#(
  parameter int STRIP_LENGTH    = 330,
  parameter int DIGIT_SPAN      = 165,
  parameter int HORIZONTAL_LEDS = 15,
  parameter int VERTICAL_LEDS   = 30
) (
  input  logic [VALUE_W-1:0] shown_value,
  input  logic [IDX_W-1:0]   led_pos,
  output logic               lit
);

  logic [15:0]          quot_prod;
  logic [4:0]           quot;
  logic [3:0]           tens;
  logic [7:0]           ones_full;
  logic [3:0]           digit [DIGIT_N];
  logic [SEG_N-1:0]     pat   [DIGIT_N];
  logic [OFF_W-1:0]     off;
  logic [DIGIT_N*SEG_N-1:0] hit;

  // v / 10 as (v * 205) >> 11, exact for 8-bit values
  assign quot_prod = 16'(shown_value) * 16'd205;
  assign quot      = quot_prod[15:11];
  assign ones_full = shown_value - 8'(quot) * 8'd10;

  always_comb begin
    if (quot >= 5'd20) begin
      tens = 4'(quot - 5'd20);
    end else if (quot >= 5'd10) begin
      tens = 4'(quot - 5'd10);
    end else begin
      tens = quot[3:0];
    end
  end

  assign digit[0] = tens;
  assign digit[1] = ones_full[3:0];
  assign off      = OFF_W'(led_pos);

  for (genvar d = 0; d < DIGIT_N; d++) begin : g_digit
    assign pat[d] = SEG_TABLE[digit[d]];
    for (genvar s = 0; s < SEG_N; s++) begin : g_seg
      localparam int ST = d * DIGIT_SPAN + SEG_NH[s] * HORIZONTAL_LEDS
                          + SEG_NV[s] * VERTICAL_LEDS;
      localparam int LN = (SEG_HORIZ[s] != 0) ? HORIZONTAL_LEDS : VERTICAL_LEDS;
      assign hit[d*SEG_N+s] = pat[d][s] && (off >= OFF_W'(ST)) &&
                              (off < OFF_W'(ST + LN));
    end
  end

  assign lit = (|hit) && (shown_value != BLANK_VALUE) &&
               (off < OFF_W'(STRIP_LENGTH));

endmodule

>>> src/ssspg_scale.sv
`timescale 1ns / 1ps

module ssspg_scale
  import ssspg_pkg::*;
(
  input  logic [CHAN_W-1:0] chan,
  input  logic [CHAN_W-1:0] bright,
  output logic [CHAN_W-1:0] scaled
);

  logic [15:0] prod;
  logic [16:0] sum;

  // p / 255 as (p + (p >> 8) + 1) >> 8, exact for p up to 255 * 255
  assign prod   = 16'(chan) * 16'(bright);
  assign sum    = 17'(prod) + 17'(prod[15:8]) + 17'd1;
  assign scaled = sum[15:8];

endmodule

>>> src/seven_segment_strip_pixel_generator_top.sv
`timescale 1ns / 1ps

// Pixel generator for a two-digit seven-segment LED strip. One LED beat is
// taken in every cycle (busy stays low) and its green, red and blue bytes
// appear on out_data with out_strobe after an input register, then segment
// decode and colour select, then the brightness multiply. The receiver cannot
// stall, so out_strobe must be taken when it shows. Write cfg_* only while
// no beat is in flight.
module seven_segment_strip_pixel_generator_top
  import ssspg_pkg::*;
#(
  parameter int STRIP_LENGTH    = 330,
  parameter int DIGIT_SPAN      = 165,
  parameter int HORIZONTAL_LEDS = 15,
  parameter int VERTICAL_LEDS   = 30
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_data_t           in_data,
  output logic               out_strobe,
  output out_data_t          out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [COLOR_W-1:0] cfg_data
);

  logic [COLOR_W-1:0] on_color_r;
  logic [CHAN_W-1:0]  bright_r;
  mode_t              mode_r;

  logic               s1_valid_r;
  in_data_t           s1_data_r;
  logic               s2_valid_r;
  logic [CHAN_W-1:0]  s2_red_r, s2_green_r, s2_blue_r;
  logic [CHAN_W-1:0]  red_nxt, green_nxt, blue_nxt;
  logic               out_strobe_r;
  out_data_t          out_data_r;
  out_data_t          out_data_nxt;
  logic               lit;
  logic               accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_color_r <= ON_COLOR_RST;
      bright_r   <= BRIGHT_RST;
      mode_r     <= MODE_RUN;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ON_COLOR:   on_color_r <= cfg_data;
        CFG_BRIGHTNESS: bright_r   <= cfg_data[CHAN_W-1:0];
        CFG_MODE:       mode_r     <= mode_t'(cfg_data[1:0]);
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      s1_valid_r   <= accept;
      s2_valid_r   <= s1_valid_r;
      out_strobe_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_data_r  <= in_data;
    s2_red_r   <= red_nxt;
    s2_green_r <= green_nxt;
    s2_blue_r  <= blue_nxt;
    out_data_r <= out_data_nxt;
  end

  ssspg_seg_hit #(
    .STRIP_LENGTH    (STRIP_LENGTH),
    .DIGIT_SPAN      (DIGIT_SPAN),
    .HORIZONTAL_LEDS (HORIZONTAL_LEDS),
    .VERTICAL_LEDS   (VERTICAL_LEDS)
  ) u_seg_hit (
    .shown_value (s1_data_r.shown_value),
    .led_pos     (s1_data_r.led_pos),
    .lit         (lit)
  );

  always_comb begin
    red_nxt   = CHAN_ZERO;
    green_nxt = CHAN_ZERO;
    blue_nxt  = CHAN_ZERO;
    if (lit) begin
      case (mode_r)
        MODE_ERROR: begin
          red_nxt = CHAN_FULL;
        end
        MODE_RESET: begin
          red_nxt   = CHAN_FULL;
          green_nxt = CHAN_FULL;
        end
        default: begin
          red_nxt   = on_color_r[23:16];
          green_nxt = on_color_r[15:8];
          blue_nxt  = on_color_r[7:0];
        end
      endcase
    end
  end

  ssspg_scale u_scale_g (
    .chan (s2_green_r), .bright (bright_r), .scaled (out_data_nxt.green_out)
  );
  ssspg_scale u_scale_r (
    .chan (s2_red_r), .bright (bright_r), .scaled (out_data_nxt.red_out)
  );
  ssspg_scale u_scale_b (
    .chan (s2_blue_r), .bright (bright_r), .scaled (out_data_nxt.blue_out)
  );

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##3 out_strobe)
    else $error("accepted beat did not produce a result after three cycles");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 3))
    else $error("result strobe without a matching accepted beat");

  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && $past(accept && in_data.shown_value == BLANK_VALUE, 3)) |->
    (out_data == '0))
    else $error("blank value produced a lit pixel");

endmodule
